// ----- src/kpmm_pkg.sv -----
// ----------------------------------------------------------------------------
// kpmm_pkg: shared types and constants for the Kronecker product multiplier
// Store sizes, request codes and the accumulator cell control word.
// ----------------------------------------------------------------------------
package kpmm_pkg;

    localparam int MAX_A_ROWS = 8;
    localparam int MAX_A_COLS = 8;
    localparam int MAX_B_ROWS = 8;
    localparam int MAX_B_COLS = 8;
    localparam int MAX_C_COLS = 8;
    localparam int RESULT_LIMIT = 8;

    localparam int A_DEPTH = MAX_A_ROWS * MAX_A_COLS;
    localparam int B_DEPTH = MAX_B_ROWS * MAX_B_COLS;
    localparam int C_ROWS  = MAX_A_COLS * MAX_B_COLS;
    localparam int C_DEPTH = C_ROWS * MAX_C_COLS;

    localparam int A_AW = $clog2(A_DEPTH);
    localparam int B_AW = $clog2(B_DEPTH);
    localparam int C_AW = $clog2(C_DEPTH);
    localparam int CR_AW = $clog2(C_ROWS);
    localparam int CC_W = $clog2(MAX_C_COLS);

    localparam int NCELL = (MAX_C_COLS < RESULT_LIMIT) ? MAX_C_COLS : RESULT_LIMIT;
    localparam int NCELL_W = $clog2(NCELL + 1);

    localparam int VAL_W = 16;
    localparam int AB_W  = 32;
    localparam int SUM_W = 53;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_LOAD_C = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [2:0] REG_A_ROWS = 3'd0;
    localparam logic [2:0] REG_A_COLS = 3'd1;
    localparam logic [2:0] REG_B_ROWS = 3'd2;
    localparam logic [2:0] REG_B_COLS = 3'd3;
    localparam logic [2:0] REG_C_COLS = 3'd4;

    typedef struct packed {
        logic clear;
        logic acc;
        logic shift;
    } cell_ctl_t;

    function automatic logic [3:0] clamp_dim(input logic [3:0] v, input int hi);
        logic [3:0] r;
        begin
            r = v;
            if (v == 4'd0)
                r = 4'd1;
            else if (int'(v) > hi)
                r = 4'(hi);
            return r;
        end
    endfunction

endpackage

// ----- src/kpmm_cell.sv -----
// ----------------------------------------------------------------------------
// kpmm_cell: one column accumulator of the chain
// Adds A*B times its C element; on shift takes the neighbor's sum.
// ----------------------------------------------------------------------------
module kpmm_cell
    import kpmm_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic signed [AB_W-1:0]  ab,
    input  logic signed [VAL_W-1:0] c_val,
    input  logic signed [SUM_W-1:0] sum_in,
    output logic signed [SUM_W-1:0] sum_out
);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [AB_W+VAL_W-1:0] prod;

    assign prod = ab * c_val;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
            sum_next = '0;
        else if (ctl.shift)
            sum_next = sum_in;
        else if (ctl.acc)
            sum_next = sum_reg + SUM_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

// ----- src/kronecker_product_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// kronecker_product_matrix_multiply: kron(A,B)*C, row by row
// Loads A, B, C elements into stores; a query streams one result row.
// ----------------------------------------------------------------------------
// channel  | valid     | stall     | payload
// request  | in_valid  | in_stall  | req_type row_index col_index elem_value
// result   | out_valid | out_stall | result_row result_col result_value bad_row last
// config   | APB write and read, pready always high
//
// A query walks j,l over n*q terms, each through the states READ, MUL and ACC
// (store read, A*B product register, then the column cells accumulate), then
// the cell chain shifts out r results. The pace is set by the shared A*B
// multiplier and one C store row read per term.
// Reset clears control and registers only; stores are undefined until written.
// A stalled result holds the chain.
module kronecker_product_matrix_multiply
    import kpmm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [5:0]              row_index,
    input  logic [2:0]              col_index,
    input  logic signed [15:0]      elem_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [5:0]              result_row,
    output logic [2:0]              result_col,
    output logic signed [SUM_W-1:0] result_value,
    output logic                    bad_row,
    output logic                    last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_BAD  = 3'd5;

    logic [3:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg, c_cols_reg;
    logic [2:0] state_reg, state_next;
    logic [2:0] j_reg, j_next, l_reg, l_next;
    logic [2:0] i_reg, k_reg;
    logic [5:0] row_reg;
    logic [NCELL_W-1:0] cnt_reg, cnt_next;
    logic [3:0] m_d, n_d, p_d, q_d, r_d;
    logic [2:0] paddr_idx;
    logic cfg_wr, in_acc;

    logic [VAL_W-1:0] a_mem [A_DEPTH];
    logic [VAL_W-1:0] b_mem [B_DEPTH];
    logic [VAL_W*MAX_C_COLS-1:0] c_mem [C_ROWS];
    logic signed [VAL_W-1:0] a_rd, b_rd;
    logic [VAL_W*MAX_C_COLS-1:0] c_rd;
    logic signed [AB_W-1:0] ab_reg;
    logic [CR_AW-1:0] c_row;

    cell_ctl_t ctl;
    logic signed [SUM_W-1:0] sums [NCELL+1];

    assign pready    = 1'b1;
    assign paddr_idx = paddr[4:2];
    assign cfg_wr    = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= 4'd1;
            a_cols_reg <= 4'd1;
            b_rows_reg <= 4'd1;
            b_cols_reg <= 4'd1;
            c_cols_reg <= 4'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr_idx)
                REG_A_ROWS: a_rows_reg <= pwdata[3:0];
                REG_A_COLS: a_cols_reg <= pwdata[3:0];
                REG_B_ROWS: b_rows_reg <= pwdata[3:0];
                REG_B_COLS: b_cols_reg <= pwdata[3:0];
                REG_C_COLS: c_cols_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr_idx)
            REG_A_ROWS: prdata[3:0] = a_rows_reg;
            REG_A_COLS: prdata[3:0] = a_cols_reg;
            REG_B_ROWS: prdata[3:0] = b_rows_reg;
            REG_B_COLS: prdata[3:0] = b_cols_reg;
            REG_C_COLS: prdata[3:0] = c_cols_reg;
            default: ;
        endcase
    end

    assign m_d = clamp_dim(a_rows_reg, MAX_A_ROWS);
    assign n_d = clamp_dim(a_cols_reg, MAX_A_COLS);
    assign p_d = clamp_dim(b_rows_reg, MAX_B_ROWS);
    assign q_d = clamp_dim(b_cols_reg, MAX_B_COLS);
    assign r_d = clamp_dim(c_cols_reg, NCELL);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;

    // stores
    always_ff @(posedge clk)
    begin
        if (in_acc && req_type == REQ_LOAD_A && row_index < 6'(MAX_A_ROWS))
            a_mem[A_AW'(row_index * MAX_A_COLS + col_index)] <= elem_value;
        if (in_acc && req_type == REQ_LOAD_B && row_index < 6'(MAX_B_ROWS))
            b_mem[B_AW'(row_index * MAX_B_COLS + col_index)] <= elem_value;
        if (in_acc && req_type == REQ_LOAD_C && 7'(row_index) < 7'(C_ROWS))
            c_mem[CR_AW'(row_index)][VAL_W*col_index +: VAL_W] <= elem_value;
    end

    assign c_row = CR_AW'(6'(j_reg) * 6'(q_d) + 6'(l_reg));

    always_ff @(posedge clk)
    begin
        a_rd <= a_mem[A_AW'(i_reg * MAX_A_COLS + j_reg)];
        b_rd <= b_mem[B_AW'(k_reg * MAX_B_COLS + l_reg)];
        c_rd <= c_mem[c_row];
        ab_reg <= a_rd * b_rd;
    end

    // row decomposition: i = row / p by repeated subtraction at query start
    logic [5:0] rem;
    logic [2:0] quo;
    always_comb
    begin
        rem = row_index;
        quo = '0;
        for (int t = 0; t < MAX_A_ROWS - 1; t++)
        begin
            if (rem >= 6'(p_d))
            begin
                rem = rem - 6'(p_d);
                quo = quo + 3'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next = j_reg;
        l_next = l_reg;
        cnt_next = cnt_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req_type == REQ_QUERY)
                begin
                    ctl.clear = 1'b1;
                    j_next = '0;
                    l_next = '0;
                    if (7'(row_index) >= 7'(m_d) * 7'(p_d))
                        state_next = ST_BAD;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:
            begin
                ctl.acc = 1'b1;
                if (4'(l_reg) + 4'd1 < q_d)
                begin
                    l_next = l_reg + 3'd1;
                    state_next = ST_READ;
                end
                else if (4'(j_reg) + 4'd1 < n_d)
                begin
                    l_next = '0;
                    j_next = j_reg + 3'd1;
                    state_next = ST_READ;
                end
                else
                begin
                    cnt_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    ctl.shift = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (NCELL_W'(cnt_reg) + 1'b1 == NCELL_W'(r_d))
                        state_next = ST_IDLE;
                end
            end
            ST_BAD:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg <= '0;
            l_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg <= j_next;
            l_reg <= l_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && req_type == REQ_QUERY)
        begin
            row_reg <= row_index;
            i_reg <= quo;
            k_reg <= rem[2:0];
        end
    end

    assign sums[NCELL] = '0;
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        kpmm_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .ab      (ab_reg),
            .c_val   (c_rd[VAL_W*g +: VAL_W]),
            .sum_in  (sums[g+1]),
            .sum_out (sums[g])
        );
    end

    assign out_valid    = (state_reg == ST_OUT) || (state_reg == ST_BAD);
    assign result_row   = row_reg;
    assign result_col   = (state_reg == ST_OUT) ? 3'(cnt_reg) : 3'd0;
    assign result_value = (state_reg == ST_OUT) ? sums[0] : '0;
    assign bad_row      = (state_reg == ST_BAD);
    assign last         = (state_reg == ST_BAD) ||
                          (NCELL_W'(cnt_reg) + 1'b1 == NCELL_W'(r_d));

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_acc)
        else $error("request accepted while busy");
    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BAD && !out_stall) |=> (state_reg == ST_IDLE))
        else $error("bad row gave more than one result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(result_value) && $stable(result_col))
        else $error("stalled result changed");

endmodule
